// File: hw/rtl/abc_note_stream_parser_macros.svh
// Assertion macros for the ABC note stream parser.
// Each macro expects clk_i and rst_ni to be visible where it is used.
`ifndef ABC_NOTE_STREAM_PARSER_MACROS_SVH
`define ABC_NOTE_STREAM_PARSER_MACROS_SVH

// The condition must hold at every clock edge outside reset.
`define ANSP_ASSERT_ALWAYS(label, cond, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond)) \
    else $error(msg);

// The consequent must hold whenever the antecedent holds.
`define ANSP_ASSERT_IMPLY(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

`endif

// File: hw/rtl/ansp_pkg.sv
// Shared types, constants and tables of the ABC note stream parser.
// Used by the queue, the front end, the back end and the top level.
`timescale 1ns / 1ps

package ansp_pkg;

  localparam int unsigned MaxOctaveMarks = 8;
  localparam int unsigned MarkW = 5;
  localparam int unsigned BaseW = 12;
  localparam int unsigned DurW = 16;
  localparam int unsigned FreqW = 19;
  localparam int unsigned ToneW = 34;
  localparam int unsigned QueueDepth = 4;
  localparam int unsigned QueuePtrW = 2;
  localparam int unsigned QueueCntW = 3;
  localparam int unsigned OutDataW = 56;

  localparam logic [7:0] ChQuote = 8'h27;
  localparam logic [7:0] ChComma = 8'h2C;
  localparam logic [7:0] ChSlash = 8'h2F;
  localparam logic [7:0] ChCaret = 8'h5E;
  localparam logic [7:0] ChUnder = 8'h5F;
  localparam logic [7:0] ChEqual = 8'h3D;
  localparam logic [7:0] ChSpace = 8'h20;
  localparam logic [7:0] ChZero = 8'h30;
  localparam logic [7:0] ChNine = 8'h39;

  typedef struct packed {
    logic                    is_err;
    logic [2:0]              letter;
    logic                    lower;
    logic signed [1:0]       acc;
    logic signed [MarkW-1:0] marks;
    logic                    slash;
    logic                    has_digit;
    logic [3:0]              digit;
    logic                    last;
  } event_t;

  typedef struct packed {
    logic [QueueCntW-1:0] count;
    logic                 empty;
    logic                 space2;
  } queue_status_t;

  typedef enum logic [1:0] {
    BackIdle,
    BackTone,
    BackDur,
    BackOut
  } back_state_e;

  // 440 Hz times 2^(r/12), unsigned with 24 fraction bits.
  function automatic logic [ToneW-1:0] tone_q24(input logic [3:0] rem);
    logic [ToneW-1:0] t;
    case (rem)
      4'd0:    t = 34'd7381975040;
      4'd1:    t = 34'd7820930118;
      4'd2:    t = 34'd8285986824;
      4'd3:    t = 34'd8778697240;
      4'd4:    t = 34'd9300705743;
      4'd5:    t = 34'd9853754486;
      4'd6:    t = 34'd10439689219;
      4'd7:    t = 34'd11060465444;
      4'd8:    t = 34'd11718154944;
      4'd9:    t = 34'd12414952697;
      4'd10:   t = 34'd13153184201;
      4'd11:   t = 34'd13935313234;
      default: t = '0;
    endcase
    return t;
  endfunction

  // Semitone offset of each letter from A.
  function automatic logic signed [4:0] letter_offset(input logic [2:0] letter);
    logic signed [4:0] o;
    case (letter)
      3'd0:    o = -5'sd9;
      3'd1:    o = -5'sd7;
      3'd2:    o = -5'sd5;
      3'd3:    o = -5'sd4;
      3'd4:    o = -5'sd2;
      3'd5:    o = 5'sd0;
      3'd6:    o = 5'sd2;
      default: o = -5'sd9;
    endcase
    return o;
  endfunction

endpackage

// File: hw/rtl/ansp_queue.sv
// Four-entry event queue between the parser front end and the back end.
// Takes up to two events per cycle and releases one. Depends on ansp_pkg.
`timescale 1ns / 1ps

module ansp_queue (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic [1:0]            push_cnt_i,
  input  ansp_pkg::event_t      wdata0_i,
  input  ansp_pkg::event_t      wdata1_i,
  input  logic                  pop_i,
  output ansp_pkg::event_t      head_o,
  output ansp_pkg::queue_status_t stat_o
);

  ansp_pkg::event_t mem_q [ansp_pkg::QueueDepth];
  logic [ansp_pkg::QueuePtrW-1:0] wptr_q, wptr_d, rptr_q, rptr_d;
  logic [ansp_pkg::QueueCntW-1:0] count_q, count_d;

  always_comb begin
    wptr_d  = wptr_q + ansp_pkg::QueuePtrW'(push_cnt_i);
    rptr_d  = rptr_q + ansp_pkg::QueuePtrW'(pop_i);
    count_d = count_q + ansp_pkg::QueueCntW'(push_cnt_i) - ansp_pkg::QueueCntW'(pop_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q  <= '0;
      rptr_q  <= '0;
      count_q <= '0;
    end else begin
      wptr_q  <= wptr_d;
      rptr_q  <= rptr_d;
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_cnt_i != 2'd0) begin
      mem_q[wptr_q] <= wdata0_i;
    end
    if (push_cnt_i == 2'd2) begin
      mem_q[ansp_pkg::QueuePtrW'(wptr_q + 1'b1)] <= wdata1_i;
    end
  end

  assign head_o        = mem_q[rptr_q];
  assign stat_o.count  = count_q;
  assign stat_o.empty  = (count_q == '0);
  assign stat_o.space2 = (count_q <= ansp_pkg::QueueCntW'(ansp_pkg::QueueDepth - 2));

endmodule

// File: hw/rtl/ansp_front.sv
// Parser front end: classifies each character and tracks the pending note.
// Emits zero, one or two events per character into the queue. Depends on ansp_pkg.
`timescale 1ns / 1ps

module ansp_front (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             accept_i,
  input  logic [7:0]       char_code_i,
  input  logic             end_of_tune_i,
  output logic [1:0]       push_cnt_o,
  output ansp_pkg::event_t ev0_o,
  output ansp_pkg::event_t ev1_o
);

  localparam logic signed [ansp_pkg::MarkW-1:0] MarkMax =
    ansp_pkg::MarkW'(ansp_pkg::MaxOctaveMarks);
  localparam logic signed [ansp_pkg::MarkW-1:0] MarkOne = ansp_pkg::MarkW'(1);

  logic [7:0] prev_q, prev_d;
  logic pv_q, pv_d;
  logic [2:0] let_q, let_d;
  logic low_q, low_d;
  logic signed [1:0] acc_q, acc_d;
  logic signed [ansp_pkg::MarkW-1:0] marks_q, marks_d;
  logic phase_q, phase_d;
  logic halt_q, halt_d;

  function automatic ansp_pkg::event_t make_note(
    input logic [2:0] letter, input logic lower, input logic signed [1:0] acc,
    input logic signed [ansp_pkg::MarkW-1:0] marks, input logic slash,
    input logic has_digit, input logic [3:0] digit);
    ansp_pkg::event_t e;
    e           = '0;
    e.letter    = letter;
    e.lower     = lower;
    e.acc       = acc;
    e.marks     = marks;
    e.slash     = slash;
    e.has_digit = has_digit;
    e.digit     = digit;
    return e;
  endfunction

  logic is_digit, is_skip, lc_valid, lc_lower;
  logic [2:0] lc;
  logic [7:0] upper;
  logic consumed;
  logic [1:0] n;
  ansp_pkg::event_t ev [2];
  ansp_pkg::event_t ev_new;

  always_comb begin
    is_digit = (char_code_i >= ansp_pkg::ChZero) && (char_code_i <= ansp_pkg::ChNine);
    lc_lower = (char_code_i >= 8'h61) && (char_code_i <= 8'h67);
    upper    = lc_lower ? (char_code_i - 8'h20) : char_code_i;
    lc_valid = 1'b1;
    case (upper)
      8'h43:   lc = 3'd0;
      8'h44:   lc = 3'd1;
      8'h45:   lc = 3'd2;
      8'h46:   lc = 3'd3;
      8'h47:   lc = 3'd4;
      8'h41:   lc = 3'd5;
      8'h42:   lc = 3'd6;
      default: begin
        lc       = 3'd0;
        lc_valid = 1'b0;
      end
    endcase
    is_skip = is_digit || (char_code_i inside {ansp_pkg::ChCaret, ansp_pkg::ChUnder,
      ansp_pkg::ChEqual, ansp_pkg::ChSlash, ansp_pkg::ChQuote, ansp_pkg::ChComma,
      ansp_pkg::ChSpace});
  end

  always_comb begin
    prev_d   = prev_q;
    pv_d     = pv_q;
    let_d    = let_q;
    low_d    = low_q;
    acc_d    = acc_q;
    marks_d  = marks_q;
    phase_d  = phase_q;
    halt_d   = halt_q;
    consumed = 1'b0;
    n        = 2'd0;
    ev[0]    = '0;
    ev[1]    = '0;
    ev_new   = '0;

    if (accept_i) begin
      if (halt_q) begin
        if (end_of_tune_i) begin
          {prev_d, pv_d, let_d, low_d, acc_d, marks_d, phase_d, halt_d} = '0;
        end
      end else begin
        if (pv_q) begin
          if (!phase_q && (char_code_i == ansp_pkg::ChQuote ||
                           char_code_i == ansp_pkg::ChComma)) begin
            if (char_code_i == ansp_pkg::ChQuote && marks_q < MarkMax) begin
              marks_d = marks_q + MarkOne;
            end
            if (char_code_i == ansp_pkg::ChComma && marks_q > -MarkMax) begin
              marks_d = marks_q - MarkOne;
            end
            consumed = 1'b1;
          end else if (!phase_q && char_code_i == ansp_pkg::ChSlash) begin
            phase_d  = 1'b1;
            consumed = 1'b1;
          end else if (is_digit) begin
            ev[0]    = make_note(let_q, low_q, acc_q, marks_q, phase_q, 1'b1,
                                 char_code_i[3:0]);
            n        = 2'd1;
            pv_d     = 1'b0;
            consumed = 1'b1;
          end else begin
            ev[0] = make_note(let_q, low_q, acc_q, marks_q, phase_q, 1'b0, 4'd0);
            n     = 2'd1;
            pv_d  = 1'b0;
          end
        end

        if (!consumed) begin
          if (lc_valid) begin
            pv_d    = 1'b1;
            let_d   = lc;
            low_d   = lc_lower;
            acc_d   = (prev_q == ansp_pkg::ChCaret) ? 2'sb01 :
                      (prev_q == ansp_pkg::ChUnder) ? 2'sb11 : 2'sb00;
            marks_d = '0;
            phase_d = 1'b0;
          end else if (!is_skip) begin
            ev_new        = '0;
            ev_new.is_err = 1'b1;
            ev[n[0]]      = ev_new;
            n             = n + 2'd1;
            halt_d        = 1'b1;
          end
        end

        prev_d = char_code_i;

        if (end_of_tune_i) begin
          if (pv_d) begin
            ev[n[0]] = make_note(let_d, low_d, acc_d, marks_d, phase_d, 1'b0, 4'd0);
            n        = n + 2'd1;
          end
          {prev_d, pv_d, let_d, low_d, acc_d, marks_d, phase_d, halt_d} = '0;
        end

        if (n == 2'd1) begin
          ev[0].last = 1'b1;
        end
        if (n == 2'd2) begin
          ev[1].last = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_q  <= '0;
      pv_q    <= 1'b0;
      let_q   <= '0;
      low_q   <= 1'b0;
      acc_q   <= '0;
      marks_q <= '0;
      phase_q <= 1'b0;
      halt_q  <= 1'b0;
    end else begin
      prev_q  <= prev_d;
      pv_q    <= pv_d;
      let_q   <= let_d;
      low_q   <= low_d;
      acc_q   <= acc_d;
      marks_q <= marks_d;
      phase_q <= phase_d;
      halt_q  <= halt_d;
    end
  end

  assign push_cnt_o = n;
  assign ev0_o      = ev[0];
  assign ev1_o      = ev[1];

endmodule

// File: hw/rtl/ansp_back.sv
// Back end: turns queued events into result transactions.
// Computes pitch, frequency and duration with a bit-serial divider. Depends on ansp_pkg.
`timescale 1ns / 1ps

module ansp_back (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic [ansp_pkg::BaseW-1:0]    base_i,
  input  ansp_pkg::event_t              head_i,
  input  logic                          avail_i,
  output logic                          pop_o,
  input  logic                          out_ready_i,
  output logic                          out_valid_o,
  output logic [ansp_pkg::OutDataW-1:0] out_data_o,
  output logic                          out_user_o,
  output logic                          out_last_o
);

  ansp_pkg::back_state_e state_q, state_d;
  ansp_pkg::event_t ev_q, ev_d;
  logic signed [7:0] semi_q, semi_d;
  logic signed [4:0] oct_q, oct_d;
  logic [3:0] rem_q, rem_d;
  logic [5:0] shift_q, shift_d;
  logic [ansp_pkg::FreqW-1:0] freq_q, freq_d;
  logic [ansp_pkg::DurW-1:0] dur_q, dur_d;
  logic [ansp_pkg::BaseW-1:0] div_q, div_d;
  logic [3:0] part_q, part_d, dvs_q, dvs_d, cnt_q, cnt_d;
  logic out_valid_q, out_valid_d;
  logic [ansp_pkg::OutDataW-1:0] out_data_q, out_data_d;
  logic out_user_q, out_user_d, out_last_q, out_last_d;

  logic signed [8:0] off_e, oct_e, acc_e, semi_w;
  logic signed [4:0] oct_w;
  logic [7:0] biased;
  logic [15:0] quo_prod;
  logic [4:0] quo;
  logic [7:0] rem_w;
  logic [4:0] trial;
  logic [ansp_pkg::ToneW-1:0] tone_w;
  logic [3:0] mul;

  always_comb begin
    state_d     = state_q;
    ev_d        = ev_q;
    semi_d      = semi_q;
    oct_d       = oct_q;
    rem_d       = rem_q;
    shift_d     = shift_q;
    freq_d      = freq_q;
    dur_d       = dur_q;
    div_d       = div_q;
    part_d      = part_q;
    dvs_d       = dvs_q;
    cnt_d       = cnt_q;
    out_valid_d = out_valid_q && !out_ready_i;
    out_data_d  = out_data_q;
    out_user_d  = out_user_q;
    out_last_d  = out_last_q;
    pop_o       = 1'b0;

    oct_w    = head_i.marks + $signed({4'b0, head_i.lower});
    off_e    = 9'(ansp_pkg::letter_offset(head_i.letter));
    oct_e    = 9'(oct_w);
    acc_e    = 9'(head_i.acc);
    semi_w   = off_e + oct_e * 9'sd12 + acc_e;
    biased   = 8'(semi_q + 8'sd120);
    quo_prod = 16'(biased) * 16'd171;
    quo      = quo_prod[15:11];
    rem_w    = biased - 8'(quo) * 8'd12;
    trial    = {part_q, div_q[ansp_pkg::BaseW-1]};
    tone_w   = ansp_pkg::tone_q24(rem_q) >> shift_q;
    mul      = ev_q.has_digit ? ev_q.digit : 4'd1;

    case (state_q)
      ansp_pkg::BackIdle: begin
        if (avail_i) begin
          pop_o  = 1'b1;
          ev_d   = head_i;
          semi_d = semi_w[7:0];
          oct_d  = oct_w;
          if (head_i.is_err) begin
            state_d = ansp_pkg::BackOut;
          end else begin
            state_d = ansp_pkg::BackTone;
          end
        end
      end
      ansp_pkg::BackTone: begin
        rem_d   = rem_w[3:0];
        shift_d = 6'd34 - 6'(quo);
        div_d   = base_i;
        part_d  = '0;
        cnt_d   = '0;
        dvs_d   = ev_q.has_digit ? ev_q.digit : 4'd2;
        state_d = ansp_pkg::BackDur;
      end
      ansp_pkg::BackDur: begin
        freq_d = tone_w[ansp_pkg::FreqW-1:0];
        if (!ev_q.slash) begin
          dur_d   = ansp_pkg::DurW'(base_i) * ansp_pkg::DurW'(mul);
          state_d = ansp_pkg::BackOut;
        end else if (dvs_q == 4'd0) begin
          dur_d   = '0;
          state_d = ansp_pkg::BackOut;
        end else begin
          if (trial >= {1'b0, dvs_q}) begin
            part_d = 4'(trial - {1'b0, dvs_q});
            div_d  = {div_q[ansp_pkg::BaseW-2:0], 1'b1};
          end else begin
            part_d = trial[3:0];
            div_d  = {div_q[ansp_pkg::BaseW-2:0], 1'b0};
          end
          cnt_d = cnt_q + 4'd1;
          if (cnt_q == 4'(ansp_pkg::BaseW - 1)) begin
            dur_d   = ansp_pkg::DurW'(div_d);
            state_d = ansp_pkg::BackOut;
          end
        end
      end
      ansp_pkg::BackOut: begin
        if (!out_valid_q || out_ready_i) begin
          out_valid_d = 1'b1;
          out_user_d  = ev_q.is_err;
          out_last_d  = ev_q.last;
          if (ev_q.is_err) begin
            out_data_d = '0;
          end else begin
            out_data_d = {3'b000, dur_q, freq_q, semi_q, oct_q, ev_q.acc, ev_q.letter};
          end
          state_d = ansp_pkg::BackIdle;
        end
      end
      default: state_d = ansp_pkg::BackIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ansp_pkg::BackIdle;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ev_q       <= ev_d;
    semi_q     <= semi_d;
    oct_q      <= oct_d;
    rem_q      <= rem_d;
    shift_q    <= shift_d;
    freq_q     <= freq_d;
    dur_q      <= dur_d;
    div_q      <= div_d;
    part_q     <= part_d;
    dvs_q      <= dvs_d;
    cnt_q      <= cnt_d;
    out_data_q <= out_data_d;
    out_user_q <= out_user_d;
    out_last_q <= out_last_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;
  assign out_user_o  = out_user_q;
  assign out_last_o  = out_last_q;

endmodule

// File: hw/rtl/abc_note_stream_parser.sv
// Top level of the ABC note stream parser: front end, event queue and back end.
// Depends on ansp_pkg, ansp_front, ansp_queue, ansp_back and the assertion macros.
`timescale 1ns / 1ps

// The parser takes one ABC character per transaction and returns note and error
// transactions. The front end accepts a character in every cycle in which the
// four-entry event queue has room for two events. The back end handles one event
// at a time: an error goes straight to the output state, a note without a slash or
// with a zero divisor passes through the tone and duration states first, and a note
// with a slash and a nonzero divisor also runs the 12-step bit-serial divider.
// The user must write base_duration_ms through cfg_we_i and cfg_wdata_i only while
// idle; the block itself does not enforce this.
module abc_note_stream_parser (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [11:0] cfg_wdata_i,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] char_code
  input  logic        s_axis_tlast,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [2:0] letter, [4:3] accidental, [9:5] octave_shift, [17:10] semitones,
  // [36:18] frequency_hz, [52:37] duration_ms, [55:53] zero
  output logic [55:0] m_axis_tdata,
  output logic        m_axis_tuser,   // [0] kind
  output logic        m_axis_tlast
);

  `include "abc_note_stream_parser_macros.svh"

  logic [ansp_pkg::BaseW-1:0] base_q;
  logic accept, back_pop;
  logic [1:0] push_cnt;
  ansp_pkg::event_t ev0, ev1, head;
  ansp_pkg::queue_status_t q_stat;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_q <= 12'd100;
    end else if (cfg_we_i) begin
      base_q <= cfg_wdata_i;
    end
  end

  assign s_axis_tready = q_stat.space2;
  assign accept        = s_axis_tvalid && s_axis_tready;

  ansp_front u_front (
    .clk_i,
    .rst_ni,
    .accept_i      (accept),
    .char_code_i   (s_axis_tdata),
    .end_of_tune_i (s_axis_tlast),
    .push_cnt_o    (push_cnt),
    .ev0_o         (ev0),
    .ev1_o         (ev1)
  );

  ansp_queue u_queue (
    .clk_i,
    .rst_ni,
    .push_cnt_i (push_cnt),
    .wdata0_i   (ev0),
    .wdata1_i   (ev1),
    .pop_i      (back_pop),
    .head_o     (head),
    .stat_o     (q_stat)
  );

  ansp_back u_back (
    .clk_i,
    .rst_ni,
    .base_i      (base_q),
    .head_i      (head),
    .avail_i     (!q_stat.empty),
    .pop_o       (back_pop),
    .out_ready_i (m_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_data_o  (m_axis_tdata),
    .out_user_o  (m_axis_tuser),
    .out_last_o  (m_axis_tlast)
  );

  `ANSP_ASSERT_ALWAYS(a_queue_bound, q_stat.count <= ansp_pkg::QueueCntW'(ansp_pkg::QueueDepth), "event queue overflow")
  `ANSP_ASSERT_IMPLY(a_pop_nonempty, back_pop, q_stat.count != '0, "pop from empty event queue")
  `ANSP_ASSERT_IMPLY(a_err_zero, m_axis_tvalid && m_axis_tuser, m_axis_tdata == '0, "error transaction carries data")
  `ANSP_ASSERT_IMPLY(a_oct_range, m_axis_tvalid && !m_axis_tuser, ($signed(m_axis_tdata[9:5]) >= -5'sd8) && ($signed(m_axis_tdata[9:5]) <= 5'sd9), "octave shift out of range")

endmodule
